[sv/integer_to_radix_text_unit_defines.svh]
// Assertion macros for the integer to radix text unit.
// Uses clk and rst of the including module; no other dependencies.
`ifndef INTEGER_TO_RADIX_TEXT_UNIT_DEFINES_SVH
`define INTEGER_TO_RADIX_TEXT_UNIT_DEFINES_SVH

// same-cycle implication, disabled in reset
`define ITRT_ASSERT_NOW(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) else $error(msg);

// next-cycle implication, disabled in reset
`define ITRT_ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) else $error(msg);

`endif

[sv/itrt_pkg.sv]
// Shared types and constants for the integer to radix text unit.
// No dependencies.
package itrt_pkg;

  localparam int MAX_RADIX  = 64;
  localparam int ALPHA_AW   = $clog2(MAX_RADIX);
  localparam int RADIX_W    = 7;
  localparam int CODE_W     = 8;
  localparam int VALUE_W    = 32;
  localparam int MAG_W      = VALUE_W + 1;
  localparam int REM_W      = ALPHA_AW;
  localparam int MAX_DIGITS = 33;
  localparam int DCNT_W     = $clog2(MAX_DIGITS + 1);
  localparam int BCNT_W     = $clog2(MAG_W);

  localparam logic [CODE_W-1:0] SIGN_PLUS  = 8'h2B;
  localparam logic [CODE_W-1:0] SIGN_MINUS = 8'h2D;

  typedef enum logic {
    CMD_LOAD    = 1'b0,
    CMD_CONVERT = 1'b1
  } cmd_t;

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_CHK_RDI,
    ST_CHK_REF,
    ST_CHK_RD,
    ST_CHK_TST,
    ST_DIV,
    ST_PUSH,
    ST_SIGN,
    ST_EMIT_RD,
    ST_EMIT
  } state_t;

endpackage

[sv/itrt_if.sv]
// Item channel interfaces for the integer to radix text unit.
// Depends on itrt_pkg for field widths.
interface itrt_cmd_if;
  logic                                  valid;
  logic                                  ready;
  logic                                  command;
  logic [itrt_pkg::ALPHA_AW-1:0]         symbol_index;
  logic [itrt_pkg::CODE_W-1:0]           symbol_code;
  logic signed [itrt_pkg::VALUE_W-1:0]   value;

  modport source (output valid, command, symbol_index, symbol_code, value, input ready);
  modport sink   (input valid, command, symbol_index, symbol_code, value, output ready);
endinterface

interface itrt_txt_if;
  logic                        valid;
  logic                        ready;
  logic [itrt_pkg::CODE_W-1:0] out_char;
  logic                        last_char;

  modport source (output valid, out_char, last_char, input ready);
  modport sink   (input valid, out_char, last_char, output ready);
endinterface

[sv/integer_to_radix_text_unit.sv]
// A load item, or a convert item with radix outside 2..64, is finished in the idle state. Otherwise
// the alphabet check reads each entry, tests it for a sign byte and compares it with every later
// entry; then comes a bit-serial division per digit, an optional sign, and the digits are
// emitted, each one held through any output stall.
// Throughput: one item at a time; a new item is taken once the previous one has left its
// last character in the output register. Reset (rst, synchronous): radix 0, alphabet reads
// as all zero, no character pending.
// Depends on itrt_pkg, itrt_if.sv and integer_to_radix_text_unit_defines.svh.
`include "integer_to_radix_text_unit_defines.svh"

module integer_to_radix_text_unit (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          radix_we,
  input  logic [itrt_pkg::RADIX_W-1:0]  radix_wdata,
  itrt_cmd_if.sink                      cmd,
  itrt_txt_if.source                    txt
);
  import itrt_pkg::*;

  // ---------------------------------------------------------------------------
  // State
  // ---------------------------------------------------------------------------
  state_t state, state_next;

  logic [RADIX_W-1:0] radix;

  // alphabet: 64 x 8 memory, valid bit per entry so unwritten entries read as zero
  logic [CODE_W-1:0]    alpha_mem [MAX_RADIX];
  logic [MAX_RADIX-1:0] alpha_vld;
  logic [CODE_W-1:0]    rd_data;
  logic                 rd_vld;
  logic [ALPHA_AW-1:0]  rd_addr;

  // pairwise duplicate check: entry idx is held in ref_sym while jdx walks the rest
  logic [CODE_W-1:0]   ref_sym;
  logic [RADIX_W-1:0]  idx;     // outer sweep position
  logic [RADIX_W-1:0]  jdx;     // inner sweep position, above idx while pairs are compared

  // conversion datapath
  logic                neg;
  logic [MAG_W-1:0]    mag;     // dividend, becomes the quotient bit by bit
  logic [REM_W-1:0]    rem;     // partial remainder, always below radix
  logic [BCNT_W-1:0]   bcnt;    // bit position within one division

  // digit stack: digits are produced least significant first and popped from the top
  logic [REM_W-1:0]    stk [MAX_DIGITS];
  logic [DCNT_W-1:0]   dcnt;

  // output register
  logic                ovalid;
  logic [CODE_W-1:0]   ochar;
  logic                olast;

  // ---------------------------------------------------------------------------
  // Derived values
  // ---------------------------------------------------------------------------
  logic               cmd_acc;
  logic               conv_start;
  logic               radix_ok;
  logic [CODE_W-1:0]  sym;
  logic               sym_sign;
  logic               pair_same;
  logic               i_end;
  logic               j_end;
  logic               slot_free;
  logic [REM_W:0]     r2;
  logic [REM_W:0]     radix_ext;
  logic [REM_W:0]     r2_diff;
  logic               q_bit;

  // control from the output decoder
  logic cmd_rdy;
  logic ref_load;
  logic j_step;
  logic i_step;
  logic div_step;
  logic push;
  logic pop;
  logic out_load;
  logic out_sign;

  assign cmd_acc    = cmd.valid && cmd_rdy;
  assign conv_start = cmd_acc && (cmd.command == CMD_CONVERT);
  assign radix_ok   = (radix >= RADIX_W'(2)) && (radix <= RADIX_W'(MAX_RADIX));

  // an entry never written reads as zero, which is an ordinary symbol
  assign sym       = rd_vld ? rd_data : '0;
  assign sym_sign  = (sym == SIGN_PLUS) || (sym == SIGN_MINUS);
  assign pair_same = (sym == ref_sym);
  assign i_end     = (idx == radix - RADIX_W'(1));
  assign j_end     = (jdx == radix - RADIX_W'(1));

  assign slot_free = !ovalid || txt.ready;

  // restoring division, one dividend bit per cycle
  assign r2        = {rem, mag[MAG_W-1]};
  assign radix_ext = (REM_W+1)'(radix);
  assign q_bit     = (r2 >= radix_ext);
  assign r2_diff   = r2 - radix_ext;

  // ---------------------------------------------------------------------------
  // Next state
  // ---------------------------------------------------------------------------
  always_comb begin
    state_next = state;
    unique case (state)
      ST_IDLE: begin
        if (conv_start) begin
          state_next = radix_ok ? ST_CHK_RDI : ST_IDLE;
        end
      end
      ST_CHK_RDI: begin
        state_next = ST_CHK_REF;
      end
      ST_CHK_REF: begin
        priority if (sym_sign) begin
          state_next = ST_IDLE;
        end else if (i_end) begin
          state_next = ST_DIV;
        end else begin
          state_next = ST_CHK_RD;
        end
      end
      ST_CHK_RD: begin
        state_next = ST_CHK_TST;
      end
      ST_CHK_TST: begin
        priority if (pair_same) begin
          state_next = ST_IDLE;
        end else if (j_end) begin
          state_next = ST_CHK_RDI;
        end else begin
          state_next = ST_CHK_RD;
        end
      end
      ST_DIV: begin
        if (bcnt == BCNT_W'(MAG_W - 1)) begin
          state_next = ST_PUSH;
        end
      end
      ST_PUSH: begin
        priority if (mag != '0) begin
          state_next = ST_DIV;
        end else if (neg) begin
          state_next = ST_SIGN;
        end else begin
          state_next = ST_EMIT_RD;
        end
      end
      ST_SIGN: begin
        if (slot_free) begin
          state_next = ST_EMIT_RD;
        end
      end
      ST_EMIT_RD: begin
        state_next = ST_EMIT;
      end
      ST_EMIT: begin
        if (slot_free) begin
          state_next = (dcnt == DCNT_W'(1)) ? ST_IDLE : ST_EMIT_RD;
        end
      end
      default: state_next = ST_IDLE;
    endcase
  end

  // ---------------------------------------------------------------------------
  // Output decoder
  // ---------------------------------------------------------------------------
  always_comb begin
    cmd_rdy  = 1'b0;
    rd_addr  = '0;
    ref_load = 1'b0;
    j_step   = 1'b0;
    i_step   = 1'b0;
    div_step = 1'b0;
    push     = 1'b0;
    pop      = 1'b0;
    out_load = 1'b0;
    out_sign = 1'b0;
    unique case (state)
      ST_IDLE:    cmd_rdy  = 1'b1;
      ST_CHK_RDI: rd_addr  = idx[ALPHA_AW-1:0];
      ST_CHK_REF: ref_load = 1'b1;
      ST_CHK_RD:  rd_addr  = jdx[ALPHA_AW-1:0];
      ST_CHK_TST: begin
        j_step = !pair_same && !j_end;
        i_step = !pair_same && j_end;
      end
      ST_DIV:     div_step = 1'b1;
      ST_PUSH:    push     = 1'b1;
      ST_SIGN: begin
        out_load = slot_free;
        out_sign = 1'b1;
      end
      ST_EMIT_RD: rd_addr = stk[0];
      ST_EMIT: begin
        // keep reading the same entry so the symbol holds through an output stall
        rd_addr  = stk[0];
        out_load = slot_free;
        pop      = slot_free;
      end
      default: cmd_rdy = 1'b0;
    endcase
  end

  assign cmd.ready     = cmd_rdy;
  assign txt.valid     = ovalid;
  assign txt.out_char  = ochar;
  assign txt.last_char = olast;

  // ---------------------------------------------------------------------------
  // Control registers
  // ---------------------------------------------------------------------------
  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= ST_IDLE;
      radix     <= '0;
      alpha_vld <= '0;
      dcnt      <= '0;
      ovalid    <= 1'b0;
    end else begin
      state <= state_next;

      if (radix_we) begin
        radix <= radix_wdata;
      end

      if (cmd_acc && (cmd.command == CMD_LOAD) &&
          ({1'b0, cmd.symbol_index} < (ALPHA_AW+1)'(MAX_RADIX))) begin
        alpha_vld[cmd.symbol_index] <= 1'b1;
      end

      priority if (conv_start) begin
        dcnt <= '0;
      end else if (push) begin
        dcnt <= dcnt + DCNT_W'(1);
      end else if (pop) begin
        dcnt <= dcnt - DCNT_W'(1);
      end

      if (out_load) begin
        ovalid <= 1'b1;
      end else if (txt.ready) begin
        ovalid <= 1'b0;
      end
    end
  end

  // ---------------------------------------------------------------------------
  // Alphabet memory: one write port, one registered read port
  // ---------------------------------------------------------------------------
  always_ff @(posedge clk) begin
    if (cmd_acc && (cmd.command == CMD_LOAD) &&
        ({1'b0, cmd.symbol_index} < (ALPHA_AW+1)'(MAX_RADIX))) begin
      alpha_mem[cmd.symbol_index] <= cmd.symbol_code;
    end
    rd_data <= alpha_mem[rd_addr];
  end

  // read valid bit alongside the data, cleared by reset
  always_ff @(posedge clk) begin
    if (rst) begin
      rd_vld <= 1'b0;
    end else begin
      rd_vld <= alpha_vld[rd_addr];
    end
  end

  // ---------------------------------------------------------------------------
  // Datapath registers
  // ---------------------------------------------------------------------------
  always_ff @(posedge clk) begin
    if (conv_start) begin
      neg  <= cmd.value[VALUE_W-1];
      // 33-bit magnitude keeps the most negative value exact
      mag  <= cmd.value[VALUE_W-1] ? (MAG_W'(0) - {cmd.value[VALUE_W-1], cmd.value})
                                   : {1'b0, cmd.value};
      rem  <= '0;
      bcnt <= '0;
      idx  <= '0;
    end else begin
      if (ref_load) begin
        ref_sym <= sym;
        jdx     <= idx + RADIX_W'(1);
      end
      if (j_step) begin
        jdx <= jdx + RADIX_W'(1);
      end
      if (i_step) begin
        idx <= idx + RADIX_W'(1);
      end
      if (div_step) begin
        rem  <= q_bit ? r2_diff[REM_W-1:0] : r2[REM_W-1:0];
        mag  <= {mag[MAG_W-2:0], q_bit};
        bcnt <= bcnt + BCNT_W'(1);
      end
      if (push) begin
        rem  <= '0;
        bcnt <= '0;
      end
    end

    if (push) begin
      stk[0] <= rem;
      for (int k = 1; k < MAX_DIGITS; k++) begin
        stk[k] <= stk[k-1];
      end
    end else if (pop) begin
      for (int k = 0; k < MAX_DIGITS - 1; k++) begin
        stk[k] <= stk[k+1];
      end
    end

    if (out_load) begin
      ochar <= out_sign ? SIGN_MINUS : sym;
      olast <= !out_sign && (dcnt == DCNT_W'(1));
    end
  end

  // ---------------------------------------------------------------------------
  // Assertions
  // ---------------------------------------------------------------------------
  `ITRT_ASSERT_NOW(a_chk_radix_range, (state == ST_CHK_RD),
                   (radix >= RADIX_W'(2)) && (radix <= RADIX_W'(MAX_RADIX)),
                   "alphabet check running with radix out of range")
  `ITRT_ASSERT_NOW(a_rem_below_radix, (state == ST_DIV), ({1'b0, rem} < radix_ext),
                   "partial remainder not below radix")
  `ITRT_ASSERT_NOW(a_stack_bound, (push), (dcnt < DCNT_W'(MAX_DIGITS)),
                   "digit stack overflow")
  `ITRT_ASSERT_NEXT(a_last_empties, (out_load && !out_sign && (dcnt == DCNT_W'(1))),
                    (dcnt == '0) && txt.last_char,
                    "last character emitted with digits left on the stack")

endmodule

[sim/integer_to_radix_text_unit_test.sv]
// Testbench for integer_to_radix_text_unit: directed and random command items with a
// self-checking text predictor. Depends on itrt_pkg, itrt_if.sv and the unit's RTL.
// Random gaps on both sides plus one long output hold-off stress the handshakes.
`timescale 1ns / 1ps

module integer_to_radix_text_unit_test;
  import itrt_pkg::*;

  // Quiet cycles the block may need after its last character: the pairwise alphabet check
  // alone runs long at radix 64, and an invalid alphabet
  // produces no character at all.
  localparam int SETTLE_CYCLES = 4500;
  // Long output hold-off used once to fill the block and stall its input.
  localparam int HOLD_CYCLES   = 500;
  // Watchdog: cycles with no item moving on either channel. The slowest legal stretch is
  // the settle wait or a radix-64 alphabet check.
  localparam int STALL_LIMIT   = 20000;
  // Item count after which no new random phase starts, directed tests included.
  localparam int TOTAL_ITEMS   = 480;
  localparam int MAX_PRINTED   = 40;

  typedef struct packed {
    logic [CODE_W-1:0] code;
    logic              last_flag;
  } text_char_t;

  logic clk = 1'b0;
  logic rst;
  logic                radix_we;
  logic [RADIX_W-1:0]  radix_wdata;

  itrt_cmd_if cmd_ch ();
  itrt_txt_if txt_ch ();

  integer_to_radix_text_unit dut (
    .clk         (clk),
    .rst         (rst),
    .radix_we    (radix_we),
    .radix_wdata (radix_wdata),
    .cmd         (cmd_ch),
    .txt         (txt_ch)
  );

  always begin
    #10 clk = 1'b1;
    #10 clk = 1'b0;
  end

  // ---------------------------------------------------------------------------------------
  // Predictor state: our own copy of the alphabet store and the radix register.
  // ---------------------------------------------------------------------------------------
  logic [CODE_W-1:0]  alphabet_mdl [MAX_RADIX];
  logic [RADIX_W-1:0] radix_mdl;
  text_char_t         text_expected [$];   // characters still owed by the block, in order

  int mismatch_count = 0;
  int items_sent     = 0;
  bit src_idle_on    = 1'b1;   // sender draws a random gap before each item
  bit sink_idle_on   = 1'b1;   // receiver draws a random stall before each character
  bit hold_req       = 1'b0;   // one-shot request for the long output hold-off

  task automatic report_mismatch(string what);
    mismatch_count++;
    if (mismatch_count <= MAX_PRINTED)
      $display("[%0t] mismatch: %s", $time, what);
  endtask

  // Valid alphabet: radix in 2..MAX_RADIX, entries in use pairwise distinct, no sign byte.
  function automatic bit alphabet_valid();
    if (radix_mdl < 2 || radix_mdl > MAX_RADIX) return 1'b0;
    for (int i = 0; i < radix_mdl; i++) begin
      if (alphabet_mdl[i] == SIGN_PLUS || alphabet_mdl[i] == SIGN_MINUS) return 1'b0;
      for (int j = i + 1; j < radix_mdl; j++)
        if (alphabet_mdl[i] == alphabet_mdl[j]) return 1'b0;
    end
    return 1'b1;
  endfunction

  // Queue the characters a convert item owes: optional '-', then digits MSD first.
  task automatic predict_text(logic signed [VALUE_W-1:0] v);
    logic [MAG_W-1:0]  mag;
    logic [MAG_W-1:0]  base;
    logic [CODE_W-1:0] digits [$];
    text_char_t        ch;
    if (alphabet_valid()) begin
      base = MAG_W'(radix_mdl);
      // 33-bit magnitude so the most negative value comes out as 2^31
      mag = v[VALUE_W-1] ? MAG_W'(0) - {v[VALUE_W-1], v} : {1'b0, v};
      do begin
        digits.push_front(alphabet_mdl[mag % base]);
        mag = mag / base;
      end while (mag != 0);
      if (v[VALUE_W-1]) begin
        ch.code      = SIGN_MINUS;
        ch.last_flag = 1'b0;
        text_expected.push_back(ch);
      end
      foreach (digits[i]) begin
        ch.code      = digits[i];
        ch.last_flag = (i == digits.size() - 1);
        text_expected.push_back(ch);
      end
    end
  endtask

  // ---------------------------------------------------------------------------------------
  // Command side. valid may stay high across back-to-back items; it is only lowered for a
  // drawn gap or by cmd_idle, so it never gets two updates in one time step.
  // ---------------------------------------------------------------------------------------
  task automatic send_item(cmd_t op, logic [ALPHA_AW-1:0] idx, logic [CODE_W-1:0] code,
                           logic signed [VALUE_W-1:0] v);
    int gap;
    gap = src_idle_on ? $urandom_range(0, 14) : 0;
    if (gap > 0) begin
      cmd_ch.valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    cmd_ch.valid        <= 1'b1;
    cmd_ch.command      <= op;
    cmd_ch.symbol_index <= idx;
    cmd_ch.symbol_code  <= code;
    cmd_ch.value        <= v;
    do @(posedge clk); while (!cmd_ch.ready);
    items_sent++;
    if (op == CMD_LOAD) alphabet_mdl[idx] = code;
    else predict_text(v);
  endtask

  // don't-care fields get random bits so every input bit toggles
  task automatic load_symbol(logic [ALPHA_AW-1:0] idx, logic [CODE_W-1:0] code);
    send_item(CMD_LOAD, idx, code, $urandom);
  endtask

  task automatic convert_value(logic signed [VALUE_W-1:0] v);
    send_item(CMD_CONVERT, ALPHA_AW'($urandom), CODE_W'($urandom), v);
  endtask

  task automatic cmd_idle();
    cmd_ch.valid <= 1'b0;
  endtask

  // Wait until every owed character has arrived, then give the block time to finish any
  // check that produces nothing.
  task automatic settle_block();
    cmd_idle();
    while (text_expected.size() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  // Radix register is only written with the block idle.
  task automatic write_radix(logic [RADIX_W-1:0] r);
    settle_block();
    radix_we    <= 1'b1;
    radix_wdata <= r;
    @(posedge clk);
    radix_we    <= 1'b0;
    radix_mdl = r;
  endtask

  // Distinct random symbols (never a sign byte) into entries 0..count-1.
  task automatic load_fresh_alphabet(int count);
    logic [CODE_W-1:0] pool [$];
    logic [CODE_W-1:0] tmp;
    int                j;
    for (int c = 0; c < 256; c++)
      if (c != SIGN_PLUS && c != SIGN_MINUS) pool.push_back(CODE_W'(c));
    for (int i = 0; i < count; i++) begin
      j       = $urandom_range(i, pool.size() - 1);
      tmp     = pool[i];
      pool[i] = pool[j];
      pool[j] = tmp;
      load_symbol(ALPHA_AW'(i), pool[i]);
    end
  endtask

  function automatic logic signed [VALUE_W-1:0] pick_value();
    case ($urandom_range(0, 9))
      0:       return 32'sh8000_0000;
      1:       return 32'sh7FFF_FFFF;
      2:       return '0;
      3:       return '1;
      4:       return VALUE_W'($urandom_range(1, 999));
      5:       return VALUE_W'(0) - VALUE_W'($urandom_range(1, 999));
      default: return $urandom;
    endcase
  endfunction

  // ---------------------------------------------------------------------------------------
  // Text side: a random stall before each character, or the long hold-off once.
  // ---------------------------------------------------------------------------------------
  initial begin : text_sink
    int stall;
    txt_ch.ready <= 1'b0;
    @(posedge clk);
    while (rst) @(posedge clk);
    forever begin
      stall = sink_idle_on ? $urandom_range(0, 14) : 0;
      if (hold_req) begin
        stall    = HOLD_CYCLES;
        hold_req = 1'b0;
      end
      if (stall > 0) begin
        txt_ch.ready <= 1'b0;
        repeat (stall) @(posedge clk);
      end
      txt_ch.ready <= 1'b1;
      do @(posedge clk); while (!txt_ch.valid);
    end
  end

  // Each accepted character is matched against the oldest one owed.
  always @(posedge clk) begin : text_checker
    text_char_t want;
    if (!rst && txt_ch.valid && txt_ch.ready) begin
      if (text_expected.size() == 0) begin
        report_mismatch($sformatf("unexpected char %02h last %0b",
                                  txt_ch.out_char, txt_ch.last_char));
      end else begin
        want = text_expected.pop_front();
        if (txt_ch.out_char !== want.code)
          report_mismatch($sformatf("out_char %02h, expected %02h",
                                    txt_ch.out_char, want.code));
        if (txt_ch.last_char !== want.last_flag)
          report_mismatch($sformatf("last_char %0b on char %02h, expected %0b",
                                    txt_ch.last_char, want.code, want.last_flag));
      end
    end
  end

  // Watchdog: nothing moving on either channel for too long means the block hung.
  int quiet_cycles = 0;
  always @(posedge clk) begin
    if (rst || (cmd_ch.valid && cmd_ch.ready) || (txt_ch.valid && txt_ch.ready)) begin
      quiet_cycles <= 0;
    end else if (quiet_cycles >= STALL_LIMIT) begin
      $display("watchdog: no item moved for %0d cycles", STALL_LIMIT);
      $display("** integer_to_radix_text_unit: FAILED **");
      $finish;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
  end

  // ---------------------------------------------------------------------------------------
  // Tests
  // ---------------------------------------------------------------------------------------

  // Radix 0 and 1 reject; radix 2 over the cleared store rejects on duplicates; then a
  // zero byte acts as an ordinary digit symbol.
  task automatic test_reset_alphabet();
    convert_value(32'sd5);
    write_radix(7'd1);
    convert_value(32'sd5);
    write_radix(7'd2);
    convert_value(32'sd5);
    load_symbol(6'd1, 8'h01);
    convert_value(32'sd5);
    convert_value(-32'sd2);
  endtask

  // A plus or minus byte among the used entries makes the alphabet invalid.
  task automatic test_sign_symbols();
    write_radix(7'd3);
    load_symbol(6'd0, "x");
    load_symbol(6'd1, "y");
    load_symbol(6'd2, SIGN_PLUS);
    convert_value(-32'sd7);
    load_symbol(6'd1, SIGN_MINUS);
    load_symbol(6'd2, "z");
    convert_value(32'sd7);
    load_symbol(6'd1, "y");
    convert_value(-32'sd7);
  endtask

  // Value extremes in decimal and in binary, zero giving the single entry-0 symbol.
  task automatic test_extreme_values();
    for (int i = 0; i < 10; i++) load_symbol(ALPHA_AW'(i), CODE_W'("0" + i));
    write_radix(7'd10);
    convert_value('0);
    convert_value(32'sh7FFF_FFFF);
    convert_value(32'sh8000_0000);
    convert_value('1);
    convert_value(-32'sd10);
    write_radix(7'd2);
    convert_value(32'sh8000_0000);
    convert_value('1);
    convert_value(32'sh7FFF_FFFF);
  endtask

  // Full 64-entry store, then radix values above the store size and back to zero.
  task automatic test_wide_radix();
    for (int i = 0; i < MAX_RADIX; i++)
      load_symbol(ALPHA_AW'(i), (i == MAX_RADIX - 1) ? 8'hFF : CODE_W'(8'h30 + i));
    write_radix(7'd64);
    convert_value(32'sh8000_0000);
    convert_value(32'sh7FFF_FFFF);
    convert_value(32'sd63);
    convert_value(-32'sd64);
    write_radix(7'd65);
    convert_value(32'sd100);
    write_radix(7'd127);
    convert_value(-32'sd100);
    write_radix(7'd0);
    convert_value(32'sd1);
  endtask

  // Long output hold-off while the sender keeps offering long binary conversions.
  task automatic test_backpressure();
    write_radix(7'd2);
    src_idle_on = 1'b0;
    hold_req    = 1'b1;
    repeat (6) convert_value(pick_value());
    src_idle_on = 1'b1;
  endtask

  // Phases: a fresh radix and alphabet (mostly valid, some deliberately broken), then a
  // run of conversions with the odd stray load mixed in. Every sixth phase has no idling.
  task automatic test_random_phases();
    int                 target;
    int                 phase;
    int                 kind;
    int                 n;
    int                 i;
    logic [RADIX_W-1:0] r;
    target = TOTAL_ITEMS;
    phase  = 0;
    while (items_sent < target) begin
      kind = $urandom_range(0, 19);
      if (kind < 12)       r = RADIX_W'($urandom_range(2, 16));
      else if (kind < 16)  r = RADIX_W'($urandom_range(17, MAX_RADIX));
      else if (kind == 16) r = RADIX_W'($urandom_range(0, 1));
      else if (kind == 17) r = RADIX_W'($urandom_range(MAX_RADIX + 1, 127));
      else                 r = RADIX_W'($urandom_range(2, MAX_RADIX));
      write_radix(r);
      src_idle_on  = (phase % 6 != 5);
      sink_idle_on = (phase % 6 != 5);
      if (r >= 2 && r <= MAX_RADIX) load_fresh_alphabet(int'(r));
      if (kind == 18) begin
        // duplicate symbol among the used entries
        i = $urandom_range(1, r - 1);
        load_symbol(ALPHA_AW'(i), alphabet_mdl[$urandom_range(0, i - 1)]);
      end else if (kind == 19) begin
        load_symbol(ALPHA_AW'($urandom_range(0, r - 1)),
                    $urandom_range(0, 1) ? SIGN_PLUS : SIGN_MINUS);
      end
      n = $urandom_range(15, 35);
      repeat (n) begin
        if ($urandom_range(0, 9) == 0) load_symbol(ALPHA_AW'($urandom), CODE_W'($urandom));
        else convert_value(pick_value());
      end
      phase++;
    end
    src_idle_on  = 1'b1;
    sink_idle_on = 1'b1;
  endtask

  initial begin : main
    foreach (alphabet_mdl[i]) alphabet_mdl[i] = '0;
    radix_mdl = '0;
    rst                 <= 1'b1;
    radix_we            <= 1'b0;
    radix_wdata         <= '0;
    cmd_ch.valid        <= 1'b0;
    cmd_ch.command      <= CMD_LOAD;
    cmd_ch.symbol_index <= '0;
    cmd_ch.symbol_code  <= '0;
    cmd_ch.value        <= '0;
    repeat (8) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    test_reset_alphabet();
    test_sign_symbols();
    test_extreme_values();
    test_wide_radix();
    test_backpressure();
    test_random_phases();

    settle_block();
    if (mismatch_count == 0)
      $display("** integer_to_radix_text_unit: PASSED **");
    else
      $display("** integer_to_radix_text_unit: FAILED **");
    $finish;
  end

endmodule
